FILE: sv/periodic_cell_neighbor_enumerator_unit_defines.svh
// Assertion macros for the periodic cell neighbor enumerator.
// Included by the top level; depends on nothing.
`ifndef PERIODIC_CELL_NEIGHBOR_ENUMERATOR_UNIT_DEFINES_SVH
`define PERIODIC_CELL_NEIGHBOR_ENUMERATOR_UNIT_DEFINES_SVH

// same-cycle implication
`define PCNE_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("pcne assertion failed");

// next-cycle implication
`define PCNE_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("pcne assertion failed");

`endif

FILE: sv/pcne_pkg.sv
// Shared types and constants for the periodic cell neighbor enumerator.
// No dependencies.
package pcne_pkg;

   localparam int          CPS_W           = 7;
   localparam int          OUT_COORD_W     = 6;
   localparam int          FLAT_W          = 18;
   localparam int          SCALE_FRAC_BITS = 16;
   localparam int          CPS_RESET_VAL   = 8;
   localparam logic [31:0] SCALE_RESET     = 32'd65536;

   // register indexes
   localparam logic REG_CELLS_PER_SIDE = 1'b0;
   localparam logic REG_CELL_SCALE     = 1'b1;

   // neighbor step codes
   localparam logic [1:0] STEP_MINUS = 2'd0;
   localparam logic [1:0] STEP_ZERO  = 2'd1;
   localparam logic [1:0] STEP_PLUS  = 2'd2;

   typedef struct packed {
      logic en1;
      logic en2;
      logic en3;
   } lane_ctrl_type;

endpackage

FILE: sv/pcne_axis_lane.sv
// One axis lane: cell coordinate, wrapped -1/0/+1 neighbors, and index terms.
// Depends on pcne_pkg.
module pcne_axis_lane #(
   parameter int CW    = 6,
   parameter int GW    = 7,
   parameter int MW    = 14,
   parameter int TW    = 20,
   parameter int SHIFT = 32
) (
   input  logic                   clock,
   input  pcne_pkg::lane_ctrl_type ctrl,
   input  logic [31:0]            pos,
   input  logic [31:0]            scale,
   input  logic [GW-1:0]          side,
   input  logic [MW-1:0]          mult,
   output logic [CW-1:0]          coord [3],
   output logic [TW-1:0]          term [3]
);

   localparam int SW = GW + 1;

   logic [63:0]   prod_ff, prod_in;
   logic [CW-1:0] nb_ff [3];
   logic [CW-1:0] nb_in [3];
   logic [CW-1:0] coord_ff [3];
   logic [TW-1:0] term_ff [3];
   logic [TW-1:0] term_in [3];

   logic [63:0]   idx;
   logic [CW-1:0] top_cell;
   logic [CW-1:0] home;
   logic [SW-1:0] cell_up;

   assign prod_in = 64'(pos) * 64'(scale);

   always_comb begin
      idx      = prod_ff >> SHIFT;
      top_cell = CW'(side - GW'(1));
      home     = (idx > 64'(top_cell)) ? top_cell : CW'(idx);
      cell_up  = SW'(home) + SW'(1);
      nb_in[pcne_pkg::STEP_MINUS] = (home == '0) ? top_cell : CW'(home - CW'(1));
      nb_in[pcne_pkg::STEP_ZERO]  = home;
      nb_in[pcne_pkg::STEP_PLUS]  = (cell_up >= SW'(side)) ? '0 : CW'(cell_up);
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         term_in[i] = TW'(TW'(nb_ff[i]) * TW'(mult));
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.en1) begin
         prod_ff <= prod_in;
      end
      if (ctrl.en2) begin
         nb_ff <= nb_in;
      end
      if (ctrl.en3) begin
         coord_ff <= nb_ff;
         term_ff  <= term_in;
      end
   end

   assign coord = coord_ff;
   assign term  = term_ff;

endmodule

FILE: sv/pcne_merge.sv
// Merge stage: steps through the 27 lane combinations and registers each result item.
// Depends on pcne_pkg.
module pcne_merge #(
   parameter int CW = 6,
   parameter int TW = 20
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   output logic                                in_ready,
   input  logic [CW-1:0]                       in_x [3],
   input  logic [CW-1:0]                       in_y [3],
   input  logic [CW-1:0]                       in_z [3],
   input  logic [TW-1:0]                       in_tx [3],
   input  logic [TW-1:0]                       in_ty [3],
   input  logic [TW-1:0]                       in_tz [3],
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [pcne_pkg::OUT_COORD_W-1:0]    rsp_cell_x,
   output logic [pcne_pkg::OUT_COORD_W-1:0]    rsp_cell_y,
   output logic [pcne_pkg::OUT_COORD_W-1:0]    rsp_cell_z,
   output logic [pcne_pkg::FLAT_W-1:0]         rsp_flat_cell,
   output logic                                rsp_last
);

   logic          hold_valid_ff, hold_valid_in;
   logic [1:0]    a_ff, a_in, b_ff, b_in, c_ff, c_in;
   logic [CW-1:0] x_ff [3];
   logic [CW-1:0] y_ff [3];
   logic [CW-1:0] z_ff [3];
   logic [TW-1:0] tx_ff [3];
   logic [TW-1:0] ty_ff [3];
   logic [TW-1:0] tz_ff [3];

   logic                              out_valid_ff, out_valid_in;
   logic [pcne_pkg::OUT_COORD_W-1:0]  out_x_ff, out_y_ff, out_z_ff;
   logic [pcne_pkg::FLAT_W-1:0]       out_flat_ff;
   logic                              out_last_ff;

   logic          out_load;
   logic          last_step;
   logic          hold_take;
   logic          hold_load;
   logic [TW+1:0] flat_sum;

   always_comb begin
      last_step = (a_ff == pcne_pkg::STEP_PLUS) && (b_ff == pcne_pkg::STEP_PLUS)
                  && (c_ff == pcne_pkg::STEP_PLUS);
      out_load  = hold_valid_ff && (!out_valid_ff || rsp_ready);
      hold_take = !hold_valid_ff || (out_load && last_step);
      hold_load = in_valid && hold_take;
      flat_sum  = (TW+2)'(tx_ff[a_ff]) + (TW+2)'(ty_ff[b_ff]) + (TW+2)'(tz_ff[c_ff]);

      a_in = a_ff;
      b_in = b_ff;
      c_in = c_ff;
      if (hold_load) begin
         a_in = pcne_pkg::STEP_MINUS;
         b_in = pcne_pkg::STEP_MINUS;
         c_in = pcne_pkg::STEP_MINUS;
      end else if (out_load) begin
         if (c_ff == pcne_pkg::STEP_PLUS) begin
            c_in = pcne_pkg::STEP_MINUS;
            if (b_ff == pcne_pkg::STEP_PLUS) begin
               b_in = pcne_pkg::STEP_MINUS;
               a_in = last_step ? pcne_pkg::STEP_MINUS : a_ff + 2'd1;
            end else begin
               b_in = b_ff + 2'd1;
            end
         end else begin
            c_in = c_ff + 2'd1;
         end
      end

      if (hold_load) begin
         hold_valid_in = 1'b1;
      end else if (out_load && last_step) begin
         hold_valid_in = 1'b0;
      end else begin
         hold_valid_in = hold_valid_ff;
      end

      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         a_ff          <= pcne_pkg::STEP_MINUS;
         b_ff          <= pcne_pkg::STEP_MINUS;
         c_ff          <= pcne_pkg::STEP_MINUS;
      end else begin
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
         a_ff          <= a_in;
         b_ff          <= b_in;
         c_ff          <= c_in;
      end
   end

   always_ff @(posedge clock) begin
      if (hold_load) begin
         x_ff  <= in_x;
         y_ff  <= in_y;
         z_ff  <= in_z;
         tx_ff <= in_tx;
         ty_ff <= in_ty;
         tz_ff <= in_tz;
      end
      if (out_load) begin
         out_x_ff    <= pcne_pkg::OUT_COORD_W'(x_ff[a_ff]);
         out_y_ff    <= pcne_pkg::OUT_COORD_W'(y_ff[b_ff]);
         out_z_ff    <= pcne_pkg::OUT_COORD_W'(z_ff[c_ff]);
         out_flat_ff <= pcne_pkg::FLAT_W'(flat_sum);
         out_last_ff <= last_step;
      end
   end

   assign in_ready      = hold_take;
   assign rsp_valid     = out_valid_ff;
   assign rsp_cell_x    = out_x_ff;
   assign rsp_cell_y    = out_y_ff;
   assign rsp_cell_z    = out_z_ff;
   assign rsp_flat_cell = out_flat_ff;
   assign rsp_last      = out_last_ff;

endmodule

FILE: sv/periodic_cell_neighbor_enumerator_unit.sv
// Periodic cell neighbor enumerator, top level: config registers, three axis lanes, merge.
// Depends on pcne_pkg, pcne_axis_lane, pcne_merge and the defines header.
// Path: an accepted position passes the lane stages, then the merge hold and output registers.
// Output: 27 items per position, one per cycle unless rsp_ready stalls it (merge stepper).
// Lanes run 3 pipeline stages (32x32 multiply, saturate and wrap, index terms).
// Reset: synchronous; clears the pipeline, sets cells_per_side to 8 and cell_scale to 1.0.
`include "periodic_cell_neighbor_enumerator_unit_defines.svh"

module periodic_cell_neighbor_enumerator_unit #(
   parameter int MAX_CELLS_PER_SIDE = 64,
   parameter int COORD_FRAC_BITS    = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [31:0]                        req_pos_x,
   input  logic [31:0]                        req_pos_y,
   input  logic [31:0]                        req_pos_z,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [pcne_pkg::OUT_COORD_W-1:0]   rsp_cell_x,
   output logic [pcne_pkg::OUT_COORD_W-1:0]   rsp_cell_y,
   output logic [pcne_pkg::OUT_COORD_W-1:0]   rsp_cell_z,
   output logic [pcne_pkg::FLAT_W-1:0]        rsp_flat_cell,
   output logic                               rsp_last,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [2:0]                         paddr,
   input  logic [31:0]                        pwdata,
   output logic [31:0]                        prdata,
   output logic                               pready
);

   localparam int GW    = $clog2(MAX_CELLS_PER_SIDE + 1);
   localparam int CW    = (MAX_CELLS_PER_SIDE > 1) ? $clog2(MAX_CELLS_PER_SIDE) : 1;
   localparam int MW    = 2 * GW;
   localparam int TW    = CW + MW;
   localparam int SHIFT = COORD_FRAC_BITS + pcne_pkg::SCALE_FRAC_BITS;
   localparam int G_RST = (pcne_pkg::CPS_RESET_VAL > MAX_CELLS_PER_SIDE) ?
                          MAX_CELLS_PER_SIDE : pcne_pkg::CPS_RESET_VAL;

   // configuration
   logic [pcne_pkg::CPS_W-1:0] cps_ff, cps_in;
   logic [31:0]                scale_ff, scale_in;
   logic [GW-1:0]              side_ff, side_in;
   logic [MW-1:0]              side_sq_ff, side_sq_in;
   logic                       wr_en;

   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;

   always_comb begin
      cps_in     = cps_ff;
      scale_in   = scale_ff;
      side_in    = side_ff;
      side_sq_in = side_sq_ff;
      if (wr_en) begin
         unique case (paddr[2])
            pcne_pkg::REG_CELLS_PER_SIDE: begin
               cps_in = pwdata[pcne_pkg::CPS_W-1:0];
               if (cps_in == '0) begin
                  side_in = GW'(1);
               end else if (32'(cps_in) > 32'(MAX_CELLS_PER_SIDE)) begin
                  side_in = GW'(MAX_CELLS_PER_SIDE);
               end else begin
                  side_in = GW'(cps_in);
               end
               side_sq_in = MW'(MW'(side_in) * MW'(side_in));
            end
            pcne_pkg::REG_CELL_SCALE: begin
               scale_in = pwdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cps_ff     <= pcne_pkg::CPS_W'(pcne_pkg::CPS_RESET_VAL);
         scale_ff   <= pcne_pkg::SCALE_RESET;
         side_ff    <= GW'(G_RST);
         side_sq_ff <= MW'(G_RST * G_RST);
      end else begin
         cps_ff     <= cps_in;
         scale_ff   <= scale_in;
         side_ff    <= side_in;
         side_sq_ff <= side_sq_in;
      end
   end

   always_comb begin
      unique case (paddr[2])
         pcne_pkg::REG_CELLS_PER_SIDE: prdata = 32'(cps_ff);
         pcne_pkg::REG_CELL_SCALE:     prdata = scale_ff;
         default:                      prdata = '0;
      endcase
   end

   // lane pipeline control
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic rdy1, rdy2, rdy3;
   logic m_in_ready;
   pcne_pkg::lane_ctrl_type lane_ctrl;

   always_comb begin
      rdy3          = !s3_valid_ff || m_in_ready;
      rdy2          = !s2_valid_ff || rdy3;
      rdy1          = !s1_valid_ff || rdy2;
      lane_ctrl.en1 = rdy1;
      lane_ctrl.en2 = rdy2;
      lane_ctrl.en3 = rdy3;
   end

   assign req_ready = rdy1 && !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            s1_valid_ff <= req_valid;
         end
         if (rdy2) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (rdy3) begin
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   logic [CW-1:0] x_nb [3];
   logic [CW-1:0] y_nb [3];
   logic [CW-1:0] z_nb [3];
   logic [TW-1:0] x_tm [3];
   logic [TW-1:0] y_tm [3];
   logic [TW-1:0] z_tm [3];

   pcne_axis_lane #(.CW(CW), .GW(GW), .MW(MW), .TW(TW), .SHIFT(SHIFT)) u_lane_x (
      .clock (clock),
      .ctrl  (lane_ctrl),
      .pos   (req_pos_x),
      .scale (scale_ff),
      .side  (side_ff),
      .mult  (side_sq_ff),
      .coord (x_nb),
      .term  (x_tm)
   );

   pcne_axis_lane #(.CW(CW), .GW(GW), .MW(MW), .TW(TW), .SHIFT(SHIFT)) u_lane_y (
      .clock (clock),
      .ctrl  (lane_ctrl),
      .pos   (req_pos_y),
      .scale (scale_ff),
      .side  (side_ff),
      .mult  (MW'(side_ff)),
      .coord (y_nb),
      .term  (y_tm)
   );

   pcne_axis_lane #(.CW(CW), .GW(GW), .MW(MW), .TW(TW), .SHIFT(SHIFT)) u_lane_z (
      .clock (clock),
      .ctrl  (lane_ctrl),
      .pos   (req_pos_z),
      .scale (scale_ff),
      .side  (side_ff),
      .mult  (MW'(1)),
      .coord (z_nb),
      .term  (z_tm)
   );

   pcne_merge #(.CW(CW), .TW(TW)) u_merge (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (s3_valid_ff),
      .in_ready      (m_in_ready),
      .in_x          (x_nb),
      .in_y          (y_nb),
      .in_z          (z_nb),
      .in_tx         (x_tm),
      .in_ty         (y_tm),
      .in_tz         (z_tm),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_cell_x    (rsp_cell_x),
      .rsp_cell_y    (rsp_cell_y),
      .rsp_cell_z    (rsp_cell_z),
      .rsp_flat_cell (rsp_flat_cell),
      .rsp_last      (rsp_last)
   );

   `PCNE_ASSERT_NEXT(a_accept_enters_lanes, clock, reset, req_valid && req_ready, s1_valid_ff)
   `PCNE_ASSERT_NOW(a_stall_only_when_full, clock, reset, !req_ready, s1_valid_ff)
   `PCNE_ASSERT_NEXT(a_no_gap_in_item, clock, reset, rsp_valid && rsp_ready && !rsp_last, rsp_valid)

endmodule

FILE: verif/pcne_checker.sv
// Checker for the periodic cell neighbor enumerator: tracks the config registers from the
// APB port, predicts the 27 neighbor cells of every accepted position and compares results.
// Depends on pcne_pkg.
module pcne_checker #(
   parameter int MAX_CELLS_PER_SIDE = 64,
   parameter int COORD_FRAC_BITS    = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic [31:0]                        req_pos_x,
   input  logic [31:0]                        req_pos_y,
   input  logic [31:0]                        req_pos_z,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic [pcne_pkg::OUT_COORD_W-1:0]   rsp_cell_x,
   input  logic [pcne_pkg::OUT_COORD_W-1:0]   rsp_cell_y,
   input  logic [pcne_pkg::OUT_COORD_W-1:0]   rsp_cell_z,
   input  logic [pcne_pkg::FLAT_W-1:0]        rsp_flat_cell,
   input  logic                               rsp_last,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [2:0]                         paddr,
   input  logic [31:0]                        pwdata,
   input  logic                               pready,
   output int                                 pending_cnt,
   output int                                 fail_cnt
);

   localparam logic [2:0] ADDR_SIDE  = {pcne_pkg::REG_CELLS_PER_SIDE, 2'b00};
   localparam logic [2:0] ADDR_SCALE = {pcne_pkg::REG_CELL_SCALE, 2'b00};

   typedef struct packed {
      logic [pcne_pkg::OUT_COORD_W-1:0] cx;
      logic [pcne_pkg::OUT_COORD_W-1:0] cy;
      logic [pcne_pkg::OUT_COORD_W-1:0] cz;
      logic [pcne_pkg::FLAT_W-1:0]      flat;
      logic                             last;
   } neighbor_cell_type;

   neighbor_cell_type          expected_cells[$];
   logic [pcne_pkg::CPS_W-1:0] side_reg = pcne_pkg::CPS_W'(pcne_pkg::CPS_RESET_VAL);
   logic [31:0]                scale_reg = pcne_pkg::SCALE_RESET;
   int                         errors = 0;
   int                         reported = 0;

   function automatic int unsigned side_in_use(input logic [pcne_pkg::CPS_W-1:0] side);
      if (side == 0) return 1;
      if (side > MAX_CELLS_PER_SIDE) return MAX_CELLS_PER_SIDE;
      return side;
   endfunction

   function automatic int unsigned cell_of(input logic [31:0] pos, input logic [31:0] scale,
                                           input int unsigned g);
      logic [63:0] prod;
      logic [63:0] idx;
      prod = 64'(pos) * 64'(scale);
      idx = prod >> (COORD_FRAC_BITS + pcne_pkg::SCALE_FRAC_BITS);
      if (idx > 64'(g - 1)) idx = 64'(g - 1);
      return idx[31:0];
   endfunction

   function automatic int unsigned step_wrap(input int unsigned c, input logic [1:0] step,
                                             input int unsigned g);
      case (step)
         pcne_pkg::STEP_MINUS: return (c == 0) ? g - 1 : c - 1;
         pcne_pkg::STEP_PLUS: return (c + 1 >= g) ? 0 : c + 1;
         default: return c;
      endcase
   endfunction

   task automatic queue_neighbors(input logic [31:0] px, input logic [31:0] py,
                                  input logic [31:0] pz);
      int unsigned       g;
      int unsigned       bx, by, bz;
      int unsigned       nx, ny, nz;
      logic [63:0]       flat;
      neighbor_cell_type nb;
      g = side_in_use(side_reg);
      bx = cell_of(px, scale_reg, g);
      by = cell_of(py, scale_reg, g);
      bz = cell_of(pz, scale_reg, g);
      // dz innermost
      for (int a = pcne_pkg::STEP_MINUS; a <= pcne_pkg::STEP_PLUS; a++) begin
         for (int b = pcne_pkg::STEP_MINUS; b <= pcne_pkg::STEP_PLUS; b++) begin
            for (int c = pcne_pkg::STEP_MINUS; c <= pcne_pkg::STEP_PLUS; c++) begin
               nx = step_wrap(bx, 2'(a), g);
               ny = step_wrap(by, 2'(b), g);
               nz = step_wrap(bz, 2'(c), g);
               flat = 64'(nx) * g * g + 64'(ny) * g + 64'(nz);
               nb.cx = nx[pcne_pkg::OUT_COORD_W-1:0];
               nb.cy = ny[pcne_pkg::OUT_COORD_W-1:0];
               nb.cz = nz[pcne_pkg::OUT_COORD_W-1:0];
               nb.flat = flat[pcne_pkg::FLAT_W-1:0];
               nb.last = (a == pcne_pkg::STEP_PLUS) && (b == pcne_pkg::STEP_PLUS) &&
                         (c == pcne_pkg::STEP_PLUS);
               expected_cells.insert(expected_cells.size(), nb);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      neighbor_cell_type want;
      if (reset) begin
         side_reg = pcne_pkg::CPS_W'(pcne_pkg::CPS_RESET_VAL);
         scale_reg = pcne_pkg::SCALE_RESET;
         expected_cells.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_cells.size() == 0) begin
               errors++;
               if (reported < 10) begin
                  reported++;
                  $display("unexpected item: x=%0d y=%0d z=%0d flat=%0d last=%0d",
                           rsp_cell_x, rsp_cell_y, rsp_cell_z, rsp_flat_cell, rsp_last);
               end
            end else begin
               want = expected_cells.pop_front();
               if (want.cx !== rsp_cell_x || want.cy !== rsp_cell_y ||
                   want.cz !== rsp_cell_z || want.flat !== rsp_flat_cell ||
                   want.last !== rsp_last) begin
                  errors++;
                  if (reported < 10) begin
                     reported++;
                     $display("mismatch: exp x=%0d y=%0d z=%0d flat=%0d last=%0d",
                              want.cx, want.cy, want.cz, want.flat, want.last);
                     $display("          got x=%0d y=%0d z=%0d flat=%0d last=%0d",
                              rsp_cell_x, rsp_cell_y, rsp_cell_z, rsp_flat_cell, rsp_last);
                  end
               end
            end
         end
         if (psel && penable && pwrite && pready) begin
            case (paddr)
               ADDR_SIDE: side_reg = pwdata[pcne_pkg::CPS_W-1:0];
               ADDR_SCALE: scale_reg = pwdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) queue_neighbors(req_pos_x, req_pos_y, req_pos_z);
      end
      pending_cnt <= expected_cells.size();
      fail_cnt <= errors;
   end

endmodule

FILE: verif/tb_top.sv
// Testbench top for the periodic cell neighbor enumerator: clock, reset, position stimulus,
// APB register writes and random result stalls; the verdict comes from pcne_checker.
// Depends on pcne_pkg, pcne_checker and the enumerator RTL.
module tb_top;

   localparam int          PHASES     = 10;
   localparam int          PHASE_LEN  = 43;
   localparam logic [2:0]  ADDR_SIDE  = {pcne_pkg::REG_CELLS_PER_SIDE, 2'b00};
   localparam logic [2:0]  ADDR_SCALE = {pcne_pkg::REG_CELL_SCALE, 2'b00};

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   logic [31:0]                      req_pos_x = '0;
   logic [31:0]                      req_pos_y = '0;
   logic [31:0]                      req_pos_z = '0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic [pcne_pkg::OUT_COORD_W-1:0] rsp_cell_x;
   logic [pcne_pkg::OUT_COORD_W-1:0] rsp_cell_y;
   logic [pcne_pkg::OUT_COORD_W-1:0] rsp_cell_z;
   logic [pcne_pkg::FLAT_W-1:0]      rsp_flat_cell;
   logic                             rsp_last;
   logic                             psel = 1'b0;
   logic                             penable = 1'b0;
   logic                             pwrite = 1'b0;
   logic [2:0]                       paddr = '0;
   logic [31:0]                      pwdata = '0;
   logic [31:0]                      prdata;
   logic                             pready;
   int                               pending;
   int                               failures;
   logic                             calm = 1'b0;
   int unsigned                      rsp_hold = 0;
   int unsigned                      stall;

   always #6 clock = ~clock;

   periodic_cell_neighbor_enumerator_unit i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_pos_x(req_pos_x), .req_pos_y(req_pos_y), .req_pos_z(req_pos_z),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_cell_x(rsp_cell_x), .rsp_cell_y(rsp_cell_y), .rsp_cell_z(rsp_cell_z),
      .rsp_flat_cell(rsp_flat_cell), .rsp_last(rsp_last),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   pcne_checker i_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_pos_x(req_pos_x), .req_pos_y(req_pos_y), .req_pos_z(req_pos_z),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_cell_x(rsp_cell_x), .rsp_cell_y(rsp_cell_y), .rsp_cell_z(rsp_cell_z),
      .rsp_flat_cell(rsp_flat_cell), .rsp_last(rsp_last),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .pready(pready),
      .pending_cnt(pending), .fail_cnt(failures)
   );

   // mostly short gaps, a few long ones
   function automatic int unsigned gap_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int unsigned side_in_use(input logic [31:0] side);
      if (side[pcne_pkg::CPS_W-1:0] == 0) return 1;
      if (side[pcne_pkg::CPS_W-1:0] > 64) return 64;
      return side[pcne_pkg::CPS_W-1:0];
   endfunction

   // aim most positions at the cells of the grid, the rest anywhere
   function automatic logic [31:0] rand_position(input int unsigned g, input logic [31:0] scale);
      logic [63:0] span;
      if (scale == 0 || $urandom_range(0, 4) == 0) return $urandom;
      span = (64'(g + 1) << 32) / 64'(scale);
      if (span >= 64'h1_0000_0000) return $urandom;
      return 32'(64'($urandom) % (span + 1));
   endfunction

   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
         rsp_ready <= 1'b0;
      end else if (calm) begin
         rsp_ready <= 1'b1;
      end else begin
         stall = gap_len();
         rsp_ready <= (stall == 0);
         if (stall > 0) rsp_hold <= stall - 1;
      end
   end

   task automatic push_position(input logic [31:0] x, input logic [31:0] y,
                                input logic [31:0] z);
      req_valid <= 1'b1;
      req_pos_x <= x;
      req_pos_y <= y;
      req_pos_z <= z;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic sender_gap();
      int unsigned n;
      n = calm ? 0 : gap_len();
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   initial begin
      logic [31:0] side_val;
      logic [31:0] scale_val;
      int unsigned g;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: 8 cells, scale 1.0
      side_val = 32'(pcne_pkg::CPS_RESET_VAL);
      scale_val = pcne_pkg::SCALE_RESET;
      push_position(32'h0, 32'h0, 32'h0);
      push_position(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_position(32'h0007_FFFF, 32'h0008_0000, 32'h0000_FFFF);
      push_position(32'h0001_0000, 32'h0006_0000, 32'h0);
      push_position(32'hAAAA_AAAA, 32'h5555_5555, 32'h0003_8000);
      push_position(32'h5555_5555, 32'h0002_FFFF, 32'hAAAA_AAAA);

      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase > 0) begin
            wait_drained();
            case (phase)
               1: begin side_val = 1; scale_val = 32'h0001_0000; end
               2: begin side_val = $urandom & ~32'h7F; scale_val = $urandom; end
               3: begin side_val = 64; scale_val = 32'h0001_0000; end
               4: begin side_val = 127; scale_val = 32'h0000_8000; end
               5: begin side_val = 64; scale_val = 32'hFFFF_FFFF; end
               6: begin side_val = 5; scale_val = 32'h0; end
               7: begin side_val = $urandom_range(1, 64); scale_val = $urandom; end
               8: begin
                  side_val = $urandom_range(2, 64);
                  scale_val = $urandom_range(32'h0001_0000, 32'h0040_0000);
               end
               default: begin
                  side_val = 32'(pcne_pkg::CPS_RESET_VAL);
                  scale_val = pcne_pkg::SCALE_RESET;
               end
            endcase
            csr_write(ADDR_SIDE, side_val);
            csr_write(ADDR_SCALE, scale_val);
            push_position(32'h0, 32'h0, 32'h0);
            push_position(32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
         end
         calm <= (phase % 4 == 3);
         g = side_in_use(side_val);
         for (int n = 0; n < PHASE_LEN; n++) begin
            sender_gap();
            if (n == PHASE_LEN / 2 && $urandom_range(0, 1) == 1) wait_drained();
            push_position(rand_position(g, scale_val), rand_position(g, scale_val),
                          rand_position(g, scale_val));
         end
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (failures == 0 && pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #(12 * 3000000);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
